/* hdl/fpp_pkg.sv */
// ----------------------------------------------------------------------------
// fpp_pkg
// Shared types, constants and lookup tables for the fixed-point power unit.
// ----------------------------------------------------------------------------
package fpp_pkg;

	localparam int LATENCY = 16;

	localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
	localparam logic [31:0] MAG_MAX = 32'h7fff_ffff;
	localparam logic [31:0] MIN_NEG = 32'h8000_0000;

	localparam logic [31:0] LG_C0 = 32'h7154_703b;
	localparam logic [31:0] LG_C1 = 32'hb8a7_1e4c;
	localparam logic [31:0] LG_C2 = 32'h7a8d_6172;
	localparam logic [31:0] LG_C3 = 32'h51c4_ad85;

	localparam logic [31:0] EX_C0 = 32'hb172_1934;
	localparam logic [31:0] EX_C1 = 32'h3d7e_b5fe;
	localparam logic [31:0] EX_C2 = 32'h0e5d_1b0d;

	// sideband that rides along the pipeline with each word
	typedef struct packed {
		logic        vld;
		logic        sp;    // result fixed by a special case
		logic        one;   // special result is 1.0 (else 0)
		logic        neg;   // negate magnitude
		logic        m15;   // most negative base, log2 forced to 15
		logic [31:0] b;     // exponent
	} side_t;

	function automatic logic [31:0] qmul(input logic [31:0] a, input logic [31:0] c);
		logic [63:0] p;
		p = 64'(a) * 64'(c);
		return p[63:32];
	endfunction

	function automatic logic [31:0] inv_tab(input logic [3:0] i);
		logic [31:0] v;
		unique case (i)
			4'd0:    v = 32'h00000000;
			4'd1:    v = 32'hf0f0f0f1;
			4'd2:    v = 32'he38e38e4;
			4'd3:    v = 32'hd79435e5;
			4'd4:    v = 32'hcccccccd;
			4'd5:    v = 32'hc30c30c3;
			4'd6:    v = 32'hba2e8ba3;
			4'd7:    v = 32'hb21642c8;
			4'd8:    v = 32'haaaaaaab;
			4'd9:    v = 32'ha3d70a3d;
			4'd10:   v = 32'h9d89d89e;
			4'd11:   v = 32'h97b425ed;
			4'd12:   v = 32'h92492492;
			4'd13:   v = 32'h8d3dcb09;
			4'd14:   v = 32'h88888889;
			default: v = 32'h84210842;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] lgc_tab(input logic [3:0] i);
		logic [31:0] v;
		unique case (i)
			4'd0:    v = 32'h00000000;
			4'd1:    v = 32'h1663f6fb;
			4'd2:    v = 32'h2b803474;
			4'd3:    v = 32'h3f782d72;
			4'd4:    v = 32'h5269e12f;
			4'd5:    v = 32'h646eea24;
			4'd6:    v = 32'h759d4f81;
			4'd7:    v = 32'h86082807;
			4'd8:    v = 32'h95c01a3a;
			4'd9:    v = 32'ha4d3c25e;
			4'd10:   v = 32'hb3500472;
			4'd11:   v = 32'hc1404eae;
			4'd12:   v = 32'hceaecfeb;
			4'd13:   v = 32'hdba4a47b;
			4'd14:   v = 32'he829fb69;
			default: v = 32'hf446359b;
		endcase
		return v;
	endfunction

	function automatic logic [48:0] pow2_tab(input logic [4:0] i);
		logic [48:0] v;
		unique case (i)
			5'd0:    v = 49'h1000000000000;
			5'd1:    v = 49'h1059b0d315857;
			5'd2:    v = 49'h10b5586cf9891;
			5'd3:    v = 49'h111301d0125b5;
			5'd4:    v = 49'h1172b83c7d518;
			5'd5:    v = 49'h11d4873168b9b;
			5'd6:    v = 49'h12387a6e75624;
			5'd7:    v = 49'h129e9df51fdee;
			5'd8:    v = 49'h1306fe0a31b71;
			5'd9:    v = 49'h1371a7373aa9d;
			5'd10:   v = 49'h13dea64c12342;
			5'd11:   v = 49'h144e086061893;
			5'd12:   v = 49'h14bfdad5362a2;
			5'd13:   v = 49'h15342b569d4f8;
			5'd14:   v = 49'h15ab07dd48543;
			5'd15:   v = 49'h16247eb03a558;
			5'd16:   v = 49'h16a09e667f3bd;
			5'd17:   v = 49'h171f75e8ec5f7;
			5'd18:   v = 49'h17a11473eb018;
			5'd19:   v = 49'h182589994cce1;
			5'd20:   v = 49'h18ace5422aa0e;
			5'd21:   v = 49'h193737b0cdc5e;
			5'd22:   v = 49'h19c49182a3f09;
			5'd23:   v = 49'h1a5503b23e256;
			5'd24:   v = 49'h1ae89f995ad3b;
			5'd25:   v = 49'h1b7f76f2fb5e4;
			5'd26:   v = 49'h1c199bdd8552a;
			5'd27:   v = 49'h1cb720dcef907;
			5'd28:   v = 49'h1d5818dcfba48;
			5'd29:   v = 49'h1dfc97337b9b6;
			5'd30:   v = 49'h1ea4afa2a490e;
			default: v = 49'h1f50765b6e454;
		endcase
		return v;
	endfunction

endpackage

/* hdl/fpp_log2.sv */
// ----------------------------------------------------------------------------
// fpp_log2
// Six-stage log2 of a Q16.16 magnitude, result in Q32.32.
// ----------------------------------------------------------------------------
module fpp_log2 (
	input  logic              clk,
	input  logic              arst_n,
	input  fpp_pkg::side_t    side_i,
	input  logic [31:0]       v_i,
	output fpp_pkg::side_t    side_o,
	output logic [63:0]       l_o
);

	fpp_pkg::side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;

	logic [31:0] r_s1, t_s2, t_s3, t_s4, t_s5;
	logic [3:0]  idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	logic [5:0]  k_s1, k_s2, k_s3, k_s4, k_s5;
	logic [31:0] t2_s3, m1_s3, m3_s3, g1_s4, g2_s4, pe_s5;
	logic [63:0] l_s6;

	logic [4:0]  msb;
	logic [5:0]  sh;
	logic [63:0] r64;
	logic [31:0] inv, tt, tsel, f;

	// normalize: leading one
	always_comb begin
		msb = 5'd0;
		for (int i = 1; i < 32; i++) begin
			if (v_i[i]) begin
				msb = 5'(i);
			end
		end
		sh  = 6'd32 - {1'b0, msb};
		r64 = {32'd0, v_i} << sh;
	end

	always_comb begin
		inv = fpp_pkg::inv_tab(idx_s1);
		tt  = inv + fpp_pkg::qmul(r_s1, inv);
		if (idx_s1 == 4'd0) begin
			tsel = r_s1;
		end else if (tt > inv) begin
			tsel = 32'd0;
		end else begin
			tsel = tt;
		end
	end

	always_comb begin
		f = t_s5 + pe_s5;
		if (f[31]) begin
			f = 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			side_s2 <= '0;
			side_s3 <= '0;
			side_s4 <= '0;
			side_s5 <= '0;
			side_s6 <= '0;
		end else begin
			side_s1 <= side_i;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
			side_s5 <= side_s4;
			side_s6 <= side_s5;
		end
	end

	always_ff @(posedge clk) begin
		r_s1   <= r64[31:0];
		idx_s1 <= r64[31:28];
		k_s1   <= {1'b0, msb} - 6'd16;

		t_s2   <= tsel;
		idx_s2 <= idx_s1;
		k_s2   <= k_s1;

		t2_s3  <= fpp_pkg::qmul(t_s2, t_s2);
		m1_s3  <= fpp_pkg::qmul(fpp_pkg::LG_C1, t_s2);
		m3_s3  <= fpp_pkg::qmul(fpp_pkg::LG_C3, t_s2);
		t_s3   <= t_s2;
		idx_s3 <= idx_s2;
		k_s3   <= k_s2;

		g1_s4  <= fpp_pkg::LG_C0 - m1_s3;
		g2_s4  <= fpp_pkg::qmul(fpp_pkg::LG_C2 - m3_s3, t2_s3);
		t_s4   <= t_s3;
		idx_s4 <= idx_s3;
		k_s4   <= k_s3;

		pe_s5  <= fpp_pkg::qmul(g1_s4 + g2_s4, t_s4);
		t_s5   <= t_s4;
		idx_s5 <= idx_s4;
		k_s5   <= k_s4;

		if (side_s5.m15) begin
			l_s6 <= {32'd15, 32'd0};
		end else begin
			l_s6 <= {{26{k_s5[5]}}, k_s5, 32'd0} + {32'd0, fpp_pkg::lgc_tab(idx_s5)}
				+ {32'd0, f};
		end
	end

	assign side_o = side_s6;
	assign l_o    = l_s6;

endmodule

/* hdl/fpp_exp2.sv */
// ----------------------------------------------------------------------------
// fpp_exp2
// Six-stage exp2 of a Q32.32 value, saturated Q16.16 magnitude out.
// ----------------------------------------------------------------------------
module fpp_exp2 (
	input  logic              clk,
	input  logic              arst_n,
	input  fpp_pkg::side_t    side_i,
	input  logic [63:0]       x_i,
	output fpp_pkg::side_t    side_o,
	output logic [31:0]       mag_o
);

	fpp_pkg::side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;

	logic [48:0] p_s1, p_s2, p_s3, p_s4, p_s5;
	logic [31:0] t_s1, t2_s2, f1_s2, m_s2, f1_s3, f2_s3, f_s4, a1_s5;
	logic [48:0] a2_s5;
	logic [1:0]  ou_s1, ou_s2, ou_s3, ou_s4, ou_s5; // {overflow, underflow}
	logic [31:0] mag_s6;

	logic signed [31:0] k;
	logic [5:0]  sh6;
	logic [63:0] res, res_sh;

	always_comb begin
		k   = $signed(x_i[63:32]);
		sh6 = 6'd16 - x_i[37:32];
	end

	always_comb begin
		res    = {15'd0, p_s5} + {32'd0, a1_s5} + {15'd0, a2_s5};
		res_sh = res >> 16;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			side_s2 <= '0;
			side_s3 <= '0;
			side_s4 <= '0;
			side_s5 <= '0;
			side_s6 <= '0;
		end else begin
			side_s1 <= side_i;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
			side_s5 <= side_s4;
			side_s6 <= side_s5;
		end
	end

	always_ff @(posedge clk) begin
		ou_s1 <= {k >= 32'sd15, k <= -32'sd16};
		p_s1  <= fpp_pkg::pow2_tab(x_i[31:27]) >> sh6[4:0];
		t_s1  <= {5'd0, x_i[26:0]};

		t2_s2 <= fpp_pkg::qmul(t_s1, t_s1);
		f1_s2 <= fpp_pkg::qmul(fpp_pkg::EX_C0, t_s1);
		m_s2  <= fpp_pkg::qmul(fpp_pkg::EX_C2, t_s1);
		p_s2  <= p_s1;
		ou_s2 <= ou_s1;

		f2_s3 <= fpp_pkg::qmul(fpp_pkg::EX_C1 + m_s2, t2_s2);
		f1_s3 <= f1_s2;
		p_s3  <= p_s2;
		ou_s3 <= ou_s2;

		f_s4  <= f1_s3 + f2_s3;
		p_s4  <= p_s3;
		ou_s4 <= ou_s3;

		a1_s5 <= fpp_pkg::qmul(p_s4[31:0], f_s4);
		a2_s5 <= 49'(p_s4[48:32]) * 49'(f_s4);
		p_s5  <= p_s4;
		ou_s5 <= ou_s4;

		if (ou_s5[1]) begin
			mag_s6 <= fpp_pkg::MAG_MAX;
		end else if (ou_s5[0]) begin
			mag_s6 <= 32'd0;
		end else if (res_sh > 64'(fpp_pkg::MAG_MAX)) begin
			mag_s6 <= fpp_pkg::MAG_MAX;
		end else begin
			mag_s6 <= res_sh[31:0];
		end
	end

	assign side_o = side_s6;
	assign mag_o  = mag_s6;

endmodule

/* hdl/fixed_point_power_unit_top.sv */
// ----------------------------------------------------------------------------
// fixed_point_power_unit_top
// Pipelined Q16.16 power: base ^ exponent = exp2(exponent * log2|base|).
// ----------------------------------------------------------------------------
//
//  channel  | handshake        | payload
//  ---------+------------------+------------------------
//  input    | start / busy     | base, exponent (Q16.16)
//  result   | done (1 cycle)   | power (Q16.16)
//
// One word enters per cycle. Between start and done every word passes the
// chain: input register, six log2 stages, two scale stages (exponent
// multiply), six exp2 stages, output register.
// busy is never raised; the result side cannot stall, so nothing is held.
// arst_n clears all valid bits; payload registers are not reset.
//
module fixed_point_power_unit_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] base,
	input  logic [31:0] exponent,
	output logic        done,
	output logic [31:0] power
);

	fpp_pkg::side_t side_in, side_s1, side_l, side_s8, side_s9, side_e;
	logic [31:0]        v_in, v_s1;
	logic [63:0]        l;
	logic signed [63:0] ph_s8;
	logic signed [64:0] pl_s8;
	logic [63:0]        x_s9;
	logic [31:0]        mag;
	logic               done_q;
	logic [31:0]        power_q;

	// special-case decode at the port
	always_comb begin
		side_in     = '0;
		side_in.vld = start;
		side_in.b   = exponent;
		side_in.neg = base[31] & exponent[16];
		side_in.m15 = (base == fpp_pkg::MIN_NEG);
		if (exponent == 32'd0) begin
			side_in.sp  = 1'b1;
			side_in.one = 1'b1;
		end else if (base == 32'd0) begin
			side_in.sp = 1'b1;
		end else if (base[31] && (exponent[15:0] != 16'd0)) begin
			// negative base needs an integer exponent
			side_in.sp = 1'b1;
		end
		v_in = base[31] ? (32'd0 - base) : base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			side_s8 <= '0;
			side_s9 <= '0;
			done_q  <= 1'b0;
		end else begin
			side_s1 <= side_in;
			side_s8 <= side_l;
			side_s9 <= side_s8;
			done_q  <= side_e.vld;
		end
	end

	always_ff @(posedge clk) begin
		v_s1 <= v_in;
	end

	fpp_log2 u_log2 (
		.clk    (clk),
		.arst_n (arst_n),
		.side_i (side_s1),
		.v_i    (v_s1),
		.side_o (side_l),
		.l_o    (l)
	);

	// scale by exponent: high word and low word products, then combine
	always_ff @(posedge clk) begin
		ph_s8 <= $signed(l[63:32]) * $signed(side_l.b);
		pl_s8 <= $signed({1'b0, l[31:0]}) * $signed({side_l.b[31], side_l.b});
		x_s9  <= {ph_s8[47:0], 16'd0} + {{16{pl_s8[63]}}, pl_s8[63:16]};
	end

	fpp_exp2 u_exp2 (
		.clk    (clk),
		.arst_n (arst_n),
		.side_i (side_s9),
		.x_i    (x_s9),
		.side_o (side_e),
		.mag_o  (mag)
	);

	always_ff @(posedge clk) begin
		if (side_e.sp) begin
			power_q <= side_e.one ? fpp_pkg::ONE_Q16 : 32'd0;
		end else if (side_e.neg) begin
			power_q <= 32'd0 - mag;
		end else begin
			power_q <= mag;
		end
	end

	assign busy  = 1'b0;
	assign done  = done_q;
	assign power = power_q;

endmodule

/* hdl/fpp_checker.sv */
// ----------------------------------------------------------------------------
// fpp_checker
// Port-level checks for the power unit, bound to the top level.
// ----------------------------------------------------------------------------
module fpp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [31:0] base,
	input logic [31:0] exponent,
	input logic        done,
	input logic [31:0] power
);

	localparam int LAT = fpp_pkg::LATENCY;

	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(start && !busy && arst_n, LAT))
		else $error("done does not follow start by the pipeline latency");

	a_zero_exp: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(start && exponent == 32'd0, LAT)) |-> power == fpp_pkg::ONE_Q16)
		else $error("zero exponent must give 1.0");

	a_zero_base: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(start && base == 32'd0 && exponent != 32'd0, LAT)) |->
		power == 32'd0)
		else $error("zero base must give 0");

	a_neg_frac: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(start && base[31] && exponent[15:0] != 16'd0, LAT)) |->
		power == 32'd0)
		else $error("negative base with fractional exponent must give 0");

endmodule

bind fixed_point_power_unit_top fpp_checker u_fpp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.base     (base),
	.exponent (exponent),
	.done     (done),
	.power    (power)
);
